### hw/rtl/strip_hit_energy_merger_top_macros.svh
// Assertion macros for the strip hit energy merger.
`ifndef STRIP_HIT_ENERGY_MERGER_TOP_MACROS_SVH
`define STRIP_HIT_ENERGY_MERGER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHEM_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("strip hit energy merger: implication violated");

// The condition must never be true.
`define SHEM_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("strip hit energy merger: forbidden condition seen");

`endif

### hw/rtl/shem_pkg.sv
`timescale 1ns / 1ps

package shem_pkg;

   localparam int DetBits      = 4;
   localparam int StripBits    = 10;
   localparam int CopyBits     = 11;
   localparam int EnergyInBits = 24;
   localparam int SumBits      = 32;
   localparam int CmdFifoDepth = 4;
   localparam int CmdPtrBits   = 2;
   localparam int CmdCntBits   = 3;

   localparam logic OpHit      = 1'b0;
   localparam logic OpEndEvent = 1'b1;

   typedef struct packed {
      logic [DetBits-1:0]   det;
      logic                 side;
      logic [StripBits-1:0] strip;
   } key_type;

   typedef struct packed {
      key_type            key;
      logic [SumBits-1:0] esum;
   } entry_type;

   typedef struct packed {
      logic               op;
      key_type            key;
      logic [SumBits-1:0] energy;
   } cmd_type;

   typedef struct packed {
      logic [DetBits-1:0]   out_det;
      logic                 out_side;
      logic [StripBits-1:0] out_strip;
      logic [SumBits-1:0]   energy_sum;
      logic                 empty_event;
      logic                 overflow;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic emitting;
      logic match_many;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HIT_CMP,
      ST_HIT_LOOK,
      ST_HIT_ADD,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_EMIT_NONE
   } back_state_type;

endpackage

### hw/rtl/strip_hit_energy_merger_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// req_      in         push, full (taken: push & !full)  operation, det_id, copy_id, energy
// rsp_      out        empty, pop (taken: pop & !empty)  out_det .. last, one port per field
//
// A hit that merges into a stored entry passes the table engine as queue pop, key compare,
// table read, then saturating add and write back; a new key is written (or, if the table is
// full, dropped) at the table-read step, and a discarded hit costs nothing there. An end-of-event
// item is popped, then each entry has a table read and a result load; an empty event, one load.
// A four-item command queue takes requests while the engine works; a result left waiting on
// rsp_ stalls the next result load, not the queue. Reset is synchronous; the table is not cleared.

`include "strip_hit_energy_merger_top_macros.svh"

module strip_hit_energy_merger_top #(
   parameter int TABLE_DEPTH     = 64,
   parameter int STRIPS_PER_SIDE = 640,
   parameter int DETECTOR_COUNT  = 16,
   parameter int ENERGY_BITS     = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_operation,
   input  logic [shem_pkg::DetBits-1:0]      req_det_id,
   input  logic [shem_pkg::CopyBits-1:0]     req_copy_id,
   input  logic [shem_pkg::EnergyInBits-1:0] req_energy,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [shem_pkg::DetBits-1:0]      rsp_out_det,
   output logic                              rsp_out_side,
   output logic [shem_pkg::StripBits-1:0]    rsp_out_strip,
   output logic [shem_pkg::SumBits-1:0]      rsp_energy_sum,
   output logic                              rsp_empty_event,
   output logic                              rsp_overflow,
   output logic                              rsp_last
);

   shem_pkg::cmd_type    front_cmd;
   logic                 front_keep;
   logic                 fifo_full;
   logic                 fifo_push;
   logic                 fifo_pop;
   logic                 fifo_not_empty;
   shem_pkg::cmd_type    fifo_head;
   logic                 back_rsp_valid;
   shem_pkg::rsp_type    back_rsp;
   shem_pkg::status_type back_status;
   logic                 empty_fields_zero;

   shem_front #(
      .STRIPS_PER_SIDE (STRIPS_PER_SIDE),
      .DETECTOR_COUNT  (DETECTOR_COUNT),
      .ENERGY_BITS     (ENERGY_BITS)
   ) u_front (
      .operation (req_operation),
      .det_id    (req_det_id),
      .copy_id   (req_copy_id),
      .energy    (req_energy),
      .cmd       (front_cmd),
      .keep      (front_keep)
   );

   assign req_full  = fifo_full;
   assign fifo_push = req_push && !fifo_full && front_keep;

   shem_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (front_cmd),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .head      (fifo_head),
      .not_empty (fifo_not_empty)
   );

   shem_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_ready (fifo_not_empty),
      .cmd_head  (fifo_head),
      .cmd_pop   (fifo_pop),
      .rsp_valid (back_rsp_valid),
      .rsp_data  (back_rsp),
      .rsp_pop   (rsp_pop),
      .status    (back_status)
   );

   assign rsp_empty       = !back_rsp_valid;
   assign rsp_out_det     = back_rsp.out_det;
   assign rsp_out_side    = back_rsp.out_side;
   assign rsp_out_strip   = back_rsp.out_strip;
   assign rsp_energy_sum  = back_rsp.energy_sum;
   assign rsp_empty_event = back_rsp.empty_event;
   assign rsp_overflow    = back_rsp.overflow;
   assign rsp_last        = back_rsp.last;

   assign empty_fields_zero = rsp_last && (rsp_energy_sum == '0) && (rsp_out_strip == '0)
                            && (rsp_out_det == '0) && !rsp_out_side;

   `SHEM_ASSERT_NEVER(a_unique_key, back_status.match_many)
   `SHEM_ASSERT_IMPLIES(a_no_pop_while_emitting, back_status.emitting, !fifo_pop)
   `SHEM_ASSERT_IMPLIES(a_empty_event_fields, !rsp_empty && rsp_empty_event, empty_fields_zero)

endmodule

### hw/rtl/shem_ram.sv
`timescale 1ns / 1ps

module shem_ram #(
   parameter int WIDTH = 47,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/shem_front.sv
`timescale 1ns / 1ps

module shem_front #(
   parameter int STRIPS_PER_SIDE = 640,
   parameter int DETECTOR_COUNT  = 16,
   parameter int ENERGY_BITS     = 24
) (
   input  logic                               operation,
   input  logic [shem_pkg::DetBits-1:0]       det_id,
   input  logic [shem_pkg::CopyBits-1:0]      copy_id,
   input  logic [shem_pkg::EnergyInBits-1:0]  energy,
   output shem_pkg::cmd_type                  cmd,
   output logic                               keep
);

   localparam logic [shem_pkg::CopyBits:0]   CopyLimit =
      (shem_pkg::CopyBits + 1)'(2 * STRIPS_PER_SIDE);
   localparam logic [shem_pkg::CopyBits-1:0] SideSplit = shem_pkg::CopyBits'(STRIPS_PER_SIDE);
   localparam logic [8:0]                    DetLimit  = 9'(DETECTOR_COUNT);

   logic [shem_pkg::EnergyInBits-1:0] energy_masked;
   logic [shem_pkg::CopyBits-1:0]     strip_all;
   logic [shem_pkg::CopyBits-1:0]     strip_upper;
   logic                              side;
   logic                              copy_ok;
   logic                              det_ok;

   always_comb begin
      for (int i = 0; i < shem_pkg::EnergyInBits; i++) begin
         energy_masked[i] = (i < ENERGY_BITS) ? energy[i] : 1'b0;
      end
   end

   assign copy_ok     = (copy_id != '0) && ({1'b0, copy_id} <= CopyLimit);
   assign det_ok      = ({5'b0, det_id} < DetLimit);
   assign strip_all   = copy_id - shem_pkg::CopyBits'(1);
   assign side        = (strip_all >= SideSplit);
   assign strip_upper = strip_all - SideSplit;

   always_comb begin
      cmd = '0;
      cmd.op = operation;
      if (operation == shem_pkg::OpHit) begin
         cmd.key.det   = det_id;
         cmd.key.side  = side;
         cmd.key.strip = side ? strip_upper[shem_pkg::StripBits-1:0]
                              : strip_all[shem_pkg::StripBits-1:0];
         cmd.energy    = {{(shem_pkg::SumBits - shem_pkg::EnergyInBits){1'b0}}, energy_masked};
      end
   end

   // Hits outside the strip or detector range are discarded here and never queued.
   assign keep = (operation == shem_pkg::OpEndEvent) || (copy_ok && det_ok);

endmodule

### hw/rtl/shem_cmd_fifo.sv
`timescale 1ns / 1ps

module shem_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  shem_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output shem_pkg::cmd_type head,
   output logic              not_empty
);

   shem_pkg::cmd_type                slot_ff [shem_pkg::CmdFifoDepth];
   logic [shem_pkg::CmdPtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [shem_pkg::CmdPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [shem_pkg::CmdCntBits-1:0] count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full      = (count_ff == shem_pkg::CmdCntBits'(shem_pkg::CmdFifoDepth));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + shem_pkg::CmdPtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + shem_pkg::CmdPtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + shem_pkg::CmdCntBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - shem_pkg::CmdCntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/shem_back.sv
`timescale 1ns / 1ps

module shem_back #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_ready,
   input  shem_pkg::cmd_type    cmd_head,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   output shem_pkg::rsp_type    rsp_data,
   input  logic                 rsp_pop,
   output shem_pkg::status_type status
);

   localparam int IdxBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntBits = $clog2(TABLE_DEPTH + 1);
   localparam int EntryBits = $bits(shem_pkg::entry_type);

   shem_pkg::back_state_type state_ff, state_in;
   shem_pkg::cmd_type        cmd_ff;
   shem_pkg::key_type        key_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   match_ff, match_in;
   logic [IdxBits-1:0]       idx_ff, match_idx;
   logic [CntBits-1:0]       count_ff;
   logic [IdxBits-1:0]       ptr_ff;
   logic                     dropped_ff;
   logic                     out_valid_ff;
   shem_pkg::rsp_type        out_ff;

   logic                     out_free;
   logic                     table_full;
   logic                     any_match;
   logic                     emit_last;
   logic                     cmd_load;
   logic                     match_load;
   logic                     idx_load;
   logic                     key_we;
   logic                     count_inc;
   logic                     drop_set;
   logic                     ptr_inc;
   logic                     clear;
   logic                     out_load;
   shem_pkg::rsp_type        out_in;
   logic                     ram_we;
   logic [IdxBits-1:0]       ram_waddr;
   shem_pkg::entry_type      ram_wdata;
   logic                     ram_re;
   logic [IdxBits-1:0]       ram_raddr;
   logic [EntryBits-1:0]     ram_rdata;
   shem_pkg::entry_type      rd_entry;
   logic [shem_pkg::SumBits:0] sum_wide;
   logic [shem_pkg::SumBits-1:0] sum_sat;

   shem_ram #(
      .WIDTH (EntryBits),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry   = shem_pkg::entry_type'(ram_rdata);
   assign out_free   = !out_valid_ff || rsp_pop;
   assign table_full = (count_ff == CntBits'(TABLE_DEPTH));
   assign any_match  = (match_ff != '0);
   assign emit_last  = (CntBits'(ptr_ff) == count_ff - CntBits'(1));
   assign sum_wide   = {1'b0, rd_entry.esum} + {1'b0, cmd_ff.energy};
   assign sum_sat    = sum_wide[shem_pkg::SumBits] ? '1 : sum_wide[shem_pkg::SumBits-1:0];

   // Only entries below the fill count take part in the key search.
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_in[i] = (CntBits'(i) < count_ff) && (key_ff[i] == cmd_ff.key);
      end
   end

   // Keys are unique, so at most one bit is set and an OR of indices encodes it.
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (match_ff[i]) begin
            match_idx = match_idx | IdxBits'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shem_pkg::ST_IDLE: begin
            if (cmd_ready) begin
               if (cmd_head.op == shem_pkg::OpHit) begin
                  state_in = shem_pkg::ST_HIT_CMP;
               end else if (count_ff == '0) begin
                  state_in = shem_pkg::ST_EMIT_NONE;
               end else begin
                  state_in = shem_pkg::ST_EMIT_RD;
               end
            end
         end
         shem_pkg::ST_HIT_CMP: begin
            state_in = shem_pkg::ST_HIT_LOOK;
         end
         shem_pkg::ST_HIT_LOOK: begin
            state_in = any_match ? shem_pkg::ST_HIT_ADD : shem_pkg::ST_IDLE;
         end
         shem_pkg::ST_HIT_ADD: begin
            state_in = shem_pkg::ST_IDLE;
         end
         shem_pkg::ST_EMIT_RD: begin
            state_in = shem_pkg::ST_EMIT_WR;
         end
         shem_pkg::ST_EMIT_WR: begin
            if (out_free) begin
               state_in = emit_last ? shem_pkg::ST_IDLE : shem_pkg::ST_EMIT_RD;
            end
         end
         shem_pkg::ST_EMIT_NONE: begin
            if (out_free) begin
               state_in = shem_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = shem_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      cmd_load   = 1'b0;
      match_load = 1'b0;
      idx_load   = 1'b0;
      key_we     = 1'b0;
      count_inc  = 1'b0;
      drop_set   = 1'b0;
      ptr_inc    = 1'b0;
      clear      = 1'b0;
      out_load   = 1'b0;
      out_in     = '0;
      ram_we     = 1'b0;
      ram_waddr  = idx_ff;
      ram_wdata  = '0;
      ram_re     = 1'b0;
      ram_raddr  = ptr_ff;
      case (state_ff)
         shem_pkg::ST_IDLE: begin
            if (cmd_ready) begin
               cmd_pop  = 1'b1;
               cmd_load = 1'b1;
            end
         end
         shem_pkg::ST_HIT_CMP: begin
            match_load = 1'b1;
         end
         shem_pkg::ST_HIT_LOOK: begin
            if (any_match) begin
               ram_re    = 1'b1;
               ram_raddr = match_idx;
               idx_load  = 1'b1;
            end else if (table_full) begin
               drop_set = 1'b1;
            end else begin
               ram_we         = 1'b1;
               ram_waddr      = count_ff[IdxBits-1:0];
               ram_wdata.key  = cmd_ff.key;
               ram_wdata.esum = cmd_ff.energy;
               key_we         = 1'b1;
               count_inc      = 1'b1;
            end
         end
         shem_pkg::ST_HIT_ADD: begin
            ram_we         = 1'b1;
            ram_waddr      = idx_ff;
            ram_wdata.key  = cmd_ff.key;
            ram_wdata.esum = sum_sat;
         end
         shem_pkg::ST_EMIT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = ptr_ff;
         end
         shem_pkg::ST_EMIT_WR: begin
            if (out_free) begin
               out_load          = 1'b1;
               out_in.out_det    = rd_entry.key.det;
               out_in.out_side   = rd_entry.key.side;
               out_in.out_strip  = rd_entry.key.strip;
               out_in.energy_sum = rd_entry.esum;
               out_in.overflow   = dropped_ff;
               out_in.last       = emit_last;
               clear             = emit_last;
               ptr_inc           = !emit_last;
            end
         end
         shem_pkg::ST_EMIT_NONE: begin
            if (out_free) begin
               out_load           = 1'b1;
               out_in.empty_event = 1'b1;
               out_in.overflow    = dropped_ff;
               out_in.last        = 1'b1;
               clear              = 1'b1;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shem_pkg::ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
         match_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (match_load) begin
            match_ff <= match_in;
         end
         if (clear) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
            ptr_ff     <= '0;
         end else begin
            if (count_inc) begin
               count_ff <= count_ff + CntBits'(1);
            end
            if (drop_set) begin
               dropped_ff <= 1'b1;
            end
            if (ptr_inc) begin
               ptr_ff <= ptr_ff + IdxBits'(1);
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_load) begin
         cmd_ff <= cmd_head;
      end
      if (idx_load) begin
         idx_ff <= match_idx;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (key_we && (count_ff[IdxBits-1:0] == IdxBits'(i))) begin
            key_ff[i] <= cmd_ff.key;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign status.emitting   = (state_ff == shem_pkg::ST_EMIT_RD)
                            || (state_ff == shem_pkg::ST_EMIT_WR)
                            || (state_ff == shem_pkg::ST_EMIT_NONE);
   assign status.match_many = ((match_ff & (match_ff - TABLE_DEPTH'(1))) != '0);

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int TableDepth    = 64;
   localparam int StripsPerSide = 640;
   localparam int CycleLimit    = 400000;
   localparam int ScriptRows    = 24;
   localparam int RandomItems   = 16;
   localparam int CeilingHits   = 257;

   typedef struct packed {
      logic                              op;
      logic [shem_pkg::DetBits-1:0]      det;
      logic [shem_pkg::CopyBits-1:0]     copy;
      logic [shem_pkg::EnergyInBits-1:0] energy;
   } hit_item_type;

   typedef struct packed {
      hit_item_type      item;
      logic              typed;
      shem_pkg::rsp_type want;
   } script_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_push = 1'b0;
   logic                              req_full;
   logic                              req_operation = shem_pkg::OpHit;
   logic [shem_pkg::DetBits-1:0]      req_det_id = '0;
   logic [shem_pkg::CopyBits-1:0]     req_copy_id = '0;
   logic [shem_pkg::EnergyInBits-1:0] req_energy = '0;
   logic                              rsp_empty;
   logic                              rsp_pop = 1'b0;
   logic [shem_pkg::DetBits-1:0]      rsp_out_det;
   logic                              rsp_out_side;
   logic [shem_pkg::StripBits-1:0]    rsp_out_strip;
   logic [shem_pkg::SumBits-1:0]      rsp_energy_sum;
   logic                              rsp_empty_event;
   logic                              rsp_overflow;
   logic                              rsp_last;

   // Mirror of the merging table and the results still owed by the block.
   shem_pkg::entry_type strip_table [TableDepth];
   int unsigned         strip_count = 0;
   logic                lost_hits = 1'b0;
   shem_pkg::rsp_type   emitted_now [$];
   shem_pkg::rsp_type   awaited_strips [$];

   script_row_type script [ScriptRows];
   int   mismatches = 0;
   int   live_items = 0;
   int   cycle_count = 0;
   int   pop_hold = 0;
   logic calm = 1'b0;
   logic tx_gappy = 1'b1;
   logic rx_gappy = 1'b1;

   strip_hit_energy_merger_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_det_id      (req_det_id),
      .req_copy_id     (req_copy_id),
      .req_energy      (req_energy),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_det     (rsp_out_det),
      .rsp_out_side    (rsp_out_side),
      .rsp_out_strip   (rsp_out_strip),
      .rsp_energy_sum  (rsp_energy_sum),
      .rsp_empty_event (rsp_empty_event),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic copy_out_of_range(input logic [shem_pkg::CopyBits-1:0] copy);
      return (copy == '0) || (copy > shem_pkg::CopyBits'(2 * StripsPerSide));
   endfunction

   // Updates the mirror for one accepted item and leaves its results in emitted_now.
   function automatic void merge_hit_or_emit(input hit_item_type it);
      logic [shem_pkg::CopyBits-1:0] s;
      shem_pkg::key_type             k;
      logic [shem_pkg::SumBits:0]    total;
      shem_pkg::rsp_type             r;
      emitted_now.delete();
      if (it.op == shem_pkg::OpHit) begin
         if (copy_out_of_range(it.copy)) return;
         s = it.copy - shem_pkg::CopyBits'(1);
         k.det = it.det;
         k.side = (s >= shem_pkg::CopyBits'(StripsPerSide));
         k.strip = shem_pkg::StripBits'(k.side ? s - shem_pkg::CopyBits'(StripsPerSide) : s);
         for (int i = 0; i < strip_count; i++) begin
            if (strip_table[i].key == k) begin
               total = {1'b0, strip_table[i].esum} + (shem_pkg::SumBits + 1)'(it.energy);
               strip_table[i].esum = total[shem_pkg::SumBits] ? '1
                                                              : total[shem_pkg::SumBits-1:0];
               return;
            end
         end
         if (strip_count >= TableDepth) begin
            lost_hits = 1'b1;
         end else begin
            strip_table[strip_count] = '{k, shem_pkg::SumBits'(it.energy)};
            strip_count++;
         end
      end else begin
         if (strip_count == 0) begin
            r = '0;
            r.empty_event = 1'b1;
            r.overflow = lost_hits;
            r.last = 1'b1;
            emitted_now.push_back(r);
         end
         for (int i = 0; i < strip_count; i++) begin
            r.out_det = strip_table[i].key.det;
            r.out_side = strip_table[i].key.side;
            r.out_strip = strip_table[i].key.strip;
            r.energy_sum = strip_table[i].esum;
            r.empty_event = 1'b0;
            r.overflow = lost_hits;
            r.last = (i == strip_count - 1);
            emitted_now.push_back(r);
         end
         strip_count = 0;
         lost_hits = 1'b0;
      end
   endfunction

   function automatic logic [shem_pkg::EnergyInBits-1:0] random_energy();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return shem_pkg::EnergyInBits'($urandom);
   endfunction

   function automatic logic [shem_pkg::CopyBits-1:0] bad_copy();
      if ($urandom_range(0, 2) == 0) return '0;
      return shem_pkg::CopyBits'($urandom_range(2 * StripsPerSide + 1, 2047));
   endfunction

   function automatic hit_item_type end_of_event();
      return '{shem_pkg::OpEndEvent, shem_pkg::DetBits'($urandom),
               shem_pkg::CopyBits'($urandom), shem_pkg::EnergyInBits'($urandom)};
   endfunction

   function automatic int field_differs(input string name,
                                        input logic [shem_pkg::SumBits-1:0] want,
                                        input logic [shem_pkg::SumBits-1:0] got);
      if (got === want) return 0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
   endfunction

   task automatic send_item(input hit_item_type it, input logic typed,
                            input shem_pkg::rsp_type want);
      req_push <= 1'b1;
      req_operation <= it.op;
      req_det_id <= it.det;
      req_copy_id <= it.copy;
      req_energy <= it.energy;
      @(posedge clock);
      while (req_full) @(posedge clock);
      merge_hit_or_emit(it);
      if (typed) begin
         awaited_strips.push_back(want);
      end else begin
         foreach (emitted_now[k]) awaited_strips.push_back(emitted_now[k]);
      end
      if (!(it.op == shem_pkg::OpHit && copy_out_of_range(it.copy))) live_items++;
      if (tx_gappy && !calm && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin : result_check
      shem_pkg::rsp_type got;
      shem_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_hold <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_out_det, rsp_out_side, rsp_out_strip, rsp_energy_sum,
                    rsp_empty_event, rsp_overflow, rsp_last};
            if (awaited_strips.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h", $time, got);
               mismatches++;
            end else begin
               want = awaited_strips.pop_front();
               mismatches += field_differs("out_det", shem_pkg::SumBits'(want.out_det),
                                           shem_pkg::SumBits'(got.out_det));
               mismatches += field_differs("out_side", shem_pkg::SumBits'(want.out_side),
                                           shem_pkg::SumBits'(got.out_side));
               mismatches += field_differs("out_strip", shem_pkg::SumBits'(want.out_strip),
                                           shem_pkg::SumBits'(got.out_strip));
               mismatches += field_differs("energy_sum", want.energy_sum, got.energy_sum);
               mismatches += field_differs("empty_event", shem_pkg::SumBits'(want.empty_event),
                                           shem_pkg::SumBits'(got.empty_event));
               mismatches += field_differs("overflow", shem_pkg::SumBits'(want.overflow),
                                           shem_pkg::SumBits'(got.overflow));
               mismatches += field_differs("last", shem_pkg::SumBits'(want.last),
                                           shem_pkg::SumBits'(got.last));
            end
         end
         if (pop_hold != 0) begin
            rsp_pop <= 1'b0;
            pop_hold <= pop_hold - 1;
         end else if (!calm && rx_gappy && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 1'b0;
            pop_hold <= $urandom_range(0, 7);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int                                pick;
      int                                nkeys;
      int                                nhits;
      int                                j;
      int                                target;
      logic [shem_pkg::DetBits-1:0]      pool_det [8];
      logic [shem_pkg::CopyBits-1:0]     pool_copy [8];
      hit_item_type                      it;

      script = '{
         '{'{shem_pkg::OpEndEvent, 4'd0, 11'd0, 24'h0}, 1'b1,
           '{4'd0, 1'b0, 10'd0, 32'd0, 1'b1, 1'b0, 1'b1}},
         '{'{shem_pkg::OpHit, 4'd0, 11'd1, 24'h0}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd0, 11'd1, 24'hFFFFFF}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd15, 11'd640, 24'h000001}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd15, 11'd641, 24'h800000}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd7, 11'd1280, 24'h123456}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd2, 11'd0, 24'hFFFFFF}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd2, 11'd1281, 24'hFFFFFF}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd15, 11'd2047, 24'hFFFFFF}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd3, 11'd641, 24'h000001}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd15, 11'd640, 24'hFFFFFF}, 1'b0, '0},
         '{'{shem_pkg::OpEndEvent, 4'd0, 11'd0, 24'h0}, 1'b0, '0},
         '{'{shem_pkg::OpEndEvent, 4'd15, 11'd2047, 24'hFFFFFF}, 1'b1,
           '{4'd0, 1'b0, 10'd0, 32'd0, 1'b1, 1'b0, 1'b1}},
         '{'{shem_pkg::OpHit, 4'd9, 11'd0, 24'h000005}, 1'b0, '0},
         '{'{shem_pkg::OpEndEvent, 4'd0, 11'd0, 24'h0}, 1'b1,
           '{4'd0, 1'b0, 10'd0, 32'd0, 1'b1, 1'b0, 1'b1}},
         '{'{shem_pkg::OpHit, 4'd15, 11'd1280, 24'hFFFFFF}, 1'b0, '0},
         '{'{shem_pkg::OpEndEvent, 4'd0, 11'd0, 24'h0}, 1'b1,
           '{4'd15, 1'b1, 10'd639, 32'h00FFFFFF, 1'b0, 1'b0, 1'b1}},
         '{'{shem_pkg::OpHit, 4'd0, 11'd1, 24'h0}, 1'b0, '0},
         '{'{shem_pkg::OpEndEvent, 4'd0, 11'd0, 24'h0}, 1'b1,
           '{4'd0, 1'b0, 10'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
         '{'{shem_pkg::OpHit, 4'd10, 11'h555, 24'h0}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd5, 11'd682, 24'hAAAAAA}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd5, 11'd682, 24'h555555}, 1'b0, '0},
         '{'{shem_pkg::OpHit, 4'd5, 11'd42, 24'h0}, 1'b0, '0},
         '{'{shem_pkg::OpEndEvent, 4'd0, 11'd0, 24'h0}, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) send_item(script[r].item, script[r].typed, script[r].want);

      // Let the block drain completely before the next item goes in.
      req_push <= 1'b0;
      while (awaited_strips.size() != 0) @(posedge clock);

      // One strip collects enough full-scale hits to reach the 32-bit ceiling.
      tx_gappy = 1'b0;
      for (int i = 0; i < CeilingHits; i++)
         send_item('{shem_pkg::OpHit, 4'd6, 11'd700, 24'hFFFFFF}, 1'b0, '0);
      // The rest of the table fills up; then a new key, a stray copy and the saturated key.
      for (int i = 0; i < TableDepth - 1; i++)
         send_item('{shem_pkg::OpHit, shem_pkg::DetBits'(i % 16),
                     shem_pkg::CopyBits'(1 + i / 16), random_energy()}, 1'b0, '0);
      send_item('{shem_pkg::OpHit, 4'd9, 11'd1000, random_energy()}, 1'b0, '0);
      send_item('{shem_pkg::OpHit, 4'd3, bad_copy(), random_energy()}, 1'b0, '0);
      send_item('{shem_pkg::OpHit, 4'd6, 11'd700, 24'hFFFFFF}, 1'b0, '0);
      send_item(end_of_event(), 1'b0, '0);

      target = live_items + RandomItems;
      while (live_items < target) begin
         calm = (live_items > target - 6);
         tx_gappy = ($urandom_range(0, 2) != 0);
         rx_gappy = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            repeat ($urandom_range(0, 2))
               send_item('{shem_pkg::OpHit, shem_pkg::DetBits'($urandom), bad_copy(),
                           random_energy()}, 1'b0, '0);
            send_item(end_of_event(), 1'b0, '0);
         end else if (pick < 20) begin
            repeat ($urandom_range(1, 6)) begin
               it = '{1'($urandom), shem_pkg::DetBits'($urandom),
                      shem_pkg::CopyBits'($urandom), shem_pkg::EnergyInBits'($urandom)};
               send_item(it, 1'b0, '0);
            end
         end else begin
            nkeys = $urandom_range(1, 8);
            for (int i = 0; i < nkeys; i++) begin
               pool_det[i] = shem_pkg::DetBits'($urandom);
               case ($urandom_range(0, 5))
                  0: pool_copy[i] = shem_pkg::CopyBits'(1);
                  1: pool_copy[i] = shem_pkg::CopyBits'(StripsPerSide);
                  2: pool_copy[i] = shem_pkg::CopyBits'(StripsPerSide + 1);
                  3: pool_copy[i] = shem_pkg::CopyBits'(2 * StripsPerSide);
                  default: pool_copy[i] = shem_pkg::CopyBits'($urandom_range(1, 2 * StripsPerSide));
               endcase
            end
            nhits = $urandom_range(1, 14);
            for (int i = 0; i < nhits; i++) begin
               j = $urandom_range(0, nkeys - 1);
               if ($urandom_range(0, 9) == 0)
                  send_item('{shem_pkg::OpHit, pool_det[j], bad_copy(), random_energy()},
                            1'b0, '0);
               else
                  send_item('{shem_pkg::OpHit, pool_det[j], pool_copy[j], random_energy()},
                            1'b0, '0);
            end
            send_item(end_of_event(), 1'b0, '0);
         end
      end
      send_item(end_of_event(), 1'b0, '0);

      req_push <= 1'b0;
      while (awaited_strips.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
